/* rtl/core/pspai_pkg.sv */
`timescale 1ns / 1ps
package pspai_pkg;

	// Shared multiplier operand and product widths.
	localparam int MUL_AW = 39;
	localparam int MUL_BW = 20;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// Divider dividend width and saturated quotient width.
	localparam int NUM_W = 55;
	localparam int QUO_W = 19;

	// Velocity accumulator width.
	localparam int ACC_W = 56;

	// Configuration port.
	localparam int CFG_DW = 17;
	localparam int CFG_IW = 3;

	localparam logic [CFG_IW-1:0] CFG_W0        = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_VEL_LIMIT = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_WEIGHT_MIN = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_WEIGHT_MAX = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_R1        = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_R2        = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_MAP_HALF  = 3'd6;

	// Command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Fitness trend codes.
	localparam logic [1:0] TREND_NONE = 2'd0;
	localparam logic [1:0] TREND_RISE = 2'd1;
	localparam logic [1:0] TREND_FALL = 2'd2;

	// log2(e) in Q14.
	localparam logic [15:0] LOG2E_Q14 = 16'd23637;

	// Upper limit of the exponent argument in Q12.
	localparam logic signed [19:0] X_MAX = 20'sd65536;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// 2^(i/16) in Q15, for i from 0 to 16.
	function automatic logic [16:0] pow2_q15(input logic [4:0] idx);
		logic [16:0] r;
		case (idx)
			5'd0: r = 17'd32768;
			5'd1: r = 17'd34219;
			5'd2: r = 17'd35734;
			5'd3: r = 17'd37316;
			5'd4: r = 17'd38968;
			5'd5: r = 17'd40694;
			5'd6: r = 17'd42495;
			5'd7: r = 17'd44377;
			5'd8: r = 17'd46341;
			5'd9: r = 17'd48393;
			5'd10: r = 17'd50535;
			5'd11: r = 17'd52773;
			5'd12: r = 17'd55109;
			5'd13: r = 17'd57549;
			5'd14: r = 17'd60097;
			5'd15: r = 17'd62758;
			5'd16: r = 17'd65536;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/pso_particle_adaptive_inertia.sv */
`timescale 1ns / 1ps
// One particle of a two-dimensional particle swarm that seeks a source. A start transaction
// loads position and velocity, sets both inertia weights to w0 and scores the particle; a
// step transaction moves it toward its own best and the swarm best, clamps speed and
// position, scores it as the negative squared distance to the source and adapts each
// inertia weight with a table-based exponential that follows the fitness trend. A particle
// whose score is zero is frozen until the next start. Every transaction yields exactly one
// result. All arithmetic goes through one registered multiplier and one restoring divider
// under a sequencer, and the block takes no new transaction while one is at work. A step
// with weight adaptation takes longest, dominated by two divisions by the map scale.
// A finished result waits in an output register, so the next transaction may be accepted
// before the previous result is taken.
module pso_particle_adaptive_inertia #(
	parameter int POSITION_LIMIT = 150,
	parameter int FRACTION_BITS  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pspai_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [pspai_pkg::CFG_DW-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic signed [17:0]                start_x,
	input  logic signed [17:0]                start_y,
	input  logic signed [17:0]                start_vx,
	input  logic signed [17:0]                start_vy,
	input  logic signed [17:0]                swarm_best_x,
	input  logic signed [17:0]                swarm_best_y,
	input  logic signed [17:0]                source_x,
	input  logic signed [17:0]                source_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [28:0]                score,
	output logic signed [17:0]                pos_x,
	output logic signed [17:0]                pos_y,
	output logic                              on_target
);
	import pspai_pkg::*;

	localparam int DEN_SH   = 3 * FRACTION_BITS - 12;
	localparam int DEN_W    = 20 + DEN_SH;
	localparam int PLIM_RAW = POSITION_LIMIT << FRACTION_BITS;
	localparam int PLIM     = (PLIM_RAW > 131071) ? 131071 : PLIM_RAW;
	localparam logic signed [18:0] PLIM_S = 19'(PLIM);

	typedef enum logic [4:0] {
		ST_IDLE, ST_V1, ST_V2, ST_V3, ST_V4, ST_V5, ST_V6, ST_V7, ST_V8,
		ST_SC1, ST_SC2, ST_SC3, ST_UPD, ST_A0, ST_A1, ST_A2, ST_A3,
		ST_DIV, ST_DIVW, ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_FIN
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] w0_q, wmin_q, wmax_q, r1_q, r2_q;
	logic [16:0] vlim_q;
	logic [8:0]  mh_q;

	// Particle state.
	logic signed [17:0] cur_q  [2];
	logic signed [17:0] spd_q  [2];
	logic signed [17:0] best_q [2];
	logic        [15:0] iner_q [2];
	logic signed [29:0] cur_score_q, last_score_q;
	logic               lsv_q;
	logic [1:0]         trend_new_q, trend_old_q;

	// Transaction and sequencer registers.
	logic               cmd_q;
	logic signed [17:0] gb_q  [2];
	logic signed [17:0] src_q [2];
	logic               ax_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [37:0]        sq_q;
	logic [DEN_W-1:0]   den_q;
	logic [NUM_W-1:0]   num_q;
	logic               neg_q;
	logic signed [19:0] x_q;
	logic signed [7:0]  n_q;
	logic [3:0]         i_q;
	logic [15:0]        e_q;

	// Output register.
	logic               out_valid_q;
	logic signed [28:0] out_score_q;
	logic signed [17:0] out_x_q, out_y_q;
	logic               out_tgt_q;

	// Shared units.
	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [MUL_PW-1:0] mul_p;
	logic                     div_start;
	div_stat_t                div_stat;
	logic [QUO_W-1:0]         div_quo;

	// Per-axis selections.
	logic        [15:0] w_sel;
	logic        [16:0] c_sel;
	logic signed [18:0] own_diff, sw_diff, d_sel, dx, dy, pos_sum;
	logic               rising, falling, improved, in_acc;
	logic [8:0]         mh_eff;
	logic signed [27:0] vraw, vlim_s;
	logic [38:0]        ssum;
	logic [38:0]        sshr;
	logic [28:0]        s_sat;
	logic signed [19:0] y_val;
	logic [11:0]        f_val;
	logic [16:0]        t_lo, t_hi, m_val;
	logic signed [7:0]  sh_val;
	logic [19:0]        pinc;
	logic [20:0]        wsum;
	logic signed [21:0] wdif;

	assign in_acc   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign w_sel    = iner_q[ax_q];
	assign c_sel    = 17'(w_sel) + 17'd4096;
	assign own_diff = 19'(best_q[ax_q]) - 19'(cur_q[ax_q]);
	assign sw_diff  = 19'(gb_q[ax_q]) - 19'(cur_q[ax_q]);
	assign d_sel    = 19'(cur_q[ax_q]) - 19'(gb_q[ax_q]);
	assign dx       = 19'(cur_q[0]) - 19'(src_q[0]);
	assign dy       = 19'(cur_q[1]) - 19'(src_q[1]);
	assign pos_sum  = 19'(cur_q[ax_q]) + 19'(spd_q[ax_q]);
	assign rising   = (trend_new_q == TREND_RISE) && (trend_old_q == TREND_RISE);
	assign falling  = (trend_new_q == TREND_FALL) && (trend_old_q == TREND_FALL);
	assign improved = !lsv_q || (cur_score_q > last_score_q);
	assign mh_eff   = (mh_q == 9'd0) ? 9'd1 : mh_q;

	assign vraw   = acc_q[ACC_W-1:28];
	assign vlim_s = $signed({11'b0, vlim_q});

	assign ssum  = 39'(sq_q) + 39'(mul_p[37:0]);
	assign sshr  = ssum >> FRACTION_BITS;
	assign s_sat = (sshr > 39'(29'h1000_0000)) ? 29'h1000_0000 : sshr[28:0];

	// Exponent: y = x*log2(e), split into integer n and fraction f.
	assign y_val = $signed(mul_p[33:14]);
	assign f_val = y_val[11:0];
	assign t_lo  = pow2_q15({1'b0, i_q});
	assign t_hi  = pow2_q15(5'({1'b0, i_q}) + 5'd1);
	assign m_val = t_lo + 17'(mul_p[19:8]);
	assign sh_val = 8'sd3 - n_q;

	assign pinc = mul_p[31:12];
	assign wsum = 21'(w_sel) + 21'(pinc);
	assign wdif = $signed({6'b0, w_sel}) - $signed({2'b0, pinc});

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_V1: begin
				mul_a = MUL_AW'(w_sel);
				mul_b = MUL_BW'(spd_q[ax_q]);
			end
			ST_V2: begin
				mul_a = MUL_AW'(c_sel);
				mul_b = MUL_BW'(r1_q);
			end
			ST_V3: begin
				mul_a = MUL_AW'(mul_p);
				mul_b = MUL_BW'(own_diff);
			end
			ST_V4: begin
				mul_a = MUL_AW'(c_sel);
				mul_b = MUL_BW'(r2_q);
			end
			ST_V5: begin
				mul_a = MUL_AW'(mul_p);
				mul_b = MUL_BW'(sw_diff);
			end
			ST_SC1: begin
				mul_a = MUL_AW'(dx);
				mul_b = MUL_BW'(dx);
			end
			ST_SC2: begin
				mul_a = MUL_AW'(dy);
				mul_b = MUL_BW'(dy);
			end
			ST_A0: begin
				mul_a = MUL_AW'(mh_eff);
				mul_b = MUL_BW'(mh_eff);
			end
			ST_A1: begin
				mul_a = MUL_AW'(d_sel);
				mul_b = MUL_BW'(d_sel);
			end
			ST_A2: begin
				mul_a = MUL_AW'(mul_p[37:0]);
				mul_b = MUL_BW'(d_sel);
			end
			ST_E1: begin
				mul_a = MUL_AW'(x_q);
				mul_b = MUL_BW'(LOG2E_Q14);
			end
			ST_E2: begin
				mul_a = MUL_AW'(pow2_q15(5'({1'b0, f_val[11:8]}) + 5'd1)
					- pow2_q15({1'b0, f_val[11:8]}));
				mul_b = MUL_BW'(f_val[7:0]);
			end
			ST_E4: begin
				mul_a = MUL_AW'(w0_q);
				mul_b = MUL_BW'(e_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = (state_q == ST_DIV);

	pspai_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	pspai_div #(
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q   <= 16'd2048;
			vlim_q <= 17'd2560;
			wmin_q <= 16'd1024;
			wmax_q <= 16'd4096;
			r1_q   <= 16'd32768;
			r2_q   <= 16'd32768;
			mh_q   <= 9'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_W0:         w0_q   <= cfg_data[15:0];
				CFG_VEL_LIMIT:  vlim_q <= cfg_data;
				CFG_WEIGHT_MIN: wmin_q <= cfg_data[15:0];
				CFG_WEIGHT_MAX: wmax_q <= cfg_data[15:0];
				CFG_R1:         r1_q   <= cfg_data[15:0];
				CFG_R2:         r2_q   <= cfg_data[15:0];
				CFG_MAP_HALF:   mh_q   <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer with the particle state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q[0]     <= '0;
			cur_q[1]     <= '0;
			spd_q[0]     <= '0;
			spd_q[1]     <= '0;
			best_q[0]    <= '0;
			best_q[1]    <= '0;
			iner_q[0]    <= 16'd2048;
			iner_q[1]    <= 16'd2048;
			cur_score_q  <= '0;
			last_score_q <= '0;
			lsv_q        <= 1'b0;
			trend_new_q  <= TREND_NONE;
			trend_old_q  <= TREND_NONE;
			ax_q         <= 1'b0;
			acc_q        <= '0;
			sq_q         <= '0;
			den_q        <= '0;
			num_q        <= '0;
			neg_q        <= 1'b0;
			x_q          <= '0;
			n_q          <= '0;
			i_q          <= '0;
			e_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// The output register loads when a result is ready and the slot is free or being taken;
			// otherwise it empties when the receiver takes it.
			if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						ax_q <= 1'b0;
						if (cmd == CMD_START) begin
							cur_q[0]  <= start_x;
							cur_q[1]  <= start_y;
							spd_q[0]  <= start_vx;
							spd_q[1]  <= start_vy;
							best_q[0] <= start_x;
							best_q[1] <= start_y;
							iner_q[0] <= w0_q;
							iner_q[1] <= w0_q;
							state_q   <= ST_SC1;
						end else if (cur_score_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_V1;
						end
					end
				end
				ST_V1: state_q <= ST_V2;
				ST_V2: begin
					acc_q   <= ACC_W'(mul_p) <<< 16;
					state_q <= ST_V3;
				end
				ST_V3: state_q <= ST_V4;
				ST_V4: begin
					acc_q   <= acc_q + ACC_W'(mul_p);
					state_q <= ST_V5;
				end
				ST_V5: state_q <= ST_V6;
				ST_V6: begin
					acc_q   <= acc_q + ACC_W'(mul_p);
					state_q <= ST_V7;
				end
				ST_V7: begin
					if (vraw > vlim_s) begin
						spd_q[ax_q] <= vlim_s[17:0];
					end else if (vraw < -vlim_s) begin
						spd_q[ax_q] <= 18'(-vlim_s);
					end else begin
						spd_q[ax_q] <= vraw[17:0];
					end
					state_q <= ST_V8;
				end
				ST_V8: begin
					if (pos_sum > PLIM_S) begin
						cur_q[ax_q] <= PLIM_S[17:0];
					end else if (pos_sum < -PLIM_S) begin
						cur_q[ax_q] <= 18'(-PLIM_S);
					end else begin
						cur_q[ax_q] <= pos_sum[17:0];
					end
					if (!ax_q) begin
						ax_q    <= 1'b1;
						state_q <= ST_V1;
					end else begin
						state_q <= ST_SC1;
					end
				end
				ST_SC1: state_q <= ST_SC2;
				ST_SC2: begin
					sq_q    <= mul_p[37:0];
					state_q <= ST_SC3;
				end
				ST_SC3: begin
					cur_score_q <= -$signed(30'(s_sat));
					if (cmd_q == CMD_START) begin
						last_score_q <= '0;
						lsv_q        <= 1'b0;
						trend_new_q  <= TREND_NONE;
						trend_old_q  <= TREND_NONE;
						state_q      <= ST_FIN;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (improved) begin
						best_q[0] <= cur_q[0];
						best_q[1] <= cur_q[1];
					end
					trend_old_q  <= trend_new_q;
					trend_new_q  <= improved ? TREND_RISE : TREND_FALL;
					last_score_q <= cur_score_q;
					lsv_q        <= 1'b1;
					ax_q         <= 1'b0;
					state_q      <= ST_A0;
				end
				ST_A0: begin
					state_q <= (rising || falling) ? ST_A1 : ST_FIN;
				end
				ST_A1: begin
					den_q   <= DEN_W'(mul_p[17:0]) << (DEN_SH + 2);
					state_q <= ST_A2;
				end
				ST_A2: begin
					if (rising) begin
						state_q <= ST_A3;
					end else begin
						num_q   <= NUM_W'(mul_p[37:0]);
						neg_q   <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_A3: begin
					neg_q   <= mul_p[MUL_PW-1];
					num_q   <= mul_p[MUL_PW-1] ? NUM_W'(-mul_p) : NUM_W'(mul_p);
					state_q <= ST_DIV;
				end
				ST_DIV: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_stat.done) begin
						if (neg_q) begin
							x_q <= ($signed({1'b0, div_quo}) > X_MAX) ? X_MAX
								: $signed({1'b0, div_quo});
						end else begin
							x_q <= -$signed({1'b0, div_quo});
						end
						state_q <= ST_E1;
					end
				end
				ST_E1: state_q <= ST_E2;
				ST_E2: begin
					n_q     <= y_val[19:12];
					i_q     <= f_val[11:8];
					state_q <= ST_E3;
				end
				ST_E3: begin
					if (n_q >= 8'sd4) begin
						e_q <= 16'hFFFF;
					end else if (sh_val > 8'sd16) begin
						e_q <= '0;
					end else begin
						e_q <= 16'(m_val >> sh_val[4:0]);
					end
					state_q <= ST_E4;
				end
				ST_E4: state_q <= ST_E5;
				ST_E5: begin
					if (rising) begin
						iner_q[ax_q] <= (wsum > 21'(wmax_q)) ? wmax_q : wsum[15:0];
					end else begin
						iner_q[ax_q] <= (wdif < $signed({6'b0, wmin_q})) ? wmin_q
							: wdif[15:0];
					end
					if (!ax_q) begin
						ax_q    <= 1'b1;
						state_q <= ST_A0;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Transaction fields and result payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= cmd;
			gb_q[0]  <= swarm_best_x;
			gb_q[1]  <= swarm_best_y;
			src_q[0] <= source_x;
			src_q[1] <= source_y;
		end
		if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
			out_score_q <= cur_score_q[28:0];
			out_x_q     <= cur_q[0];
			out_y_q     <= cur_q[1];
			out_tgt_q   <= (cur_score_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign score     = out_score_q;
	assign pos_x     = out_x_q;
	assign pos_y     = out_y_q;
	assign on_target = out_tgt_q;

`ifndef NO_ASSERTIONS
	// The divider only runs while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIVW))
		else $error("divider busy outside of its wait state");

	// A delivered result flags on_target exactly when its score is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (on_target == (score == 29'sd0)))
		else $error("on_target disagrees with score");

	// No second transaction is taken right after one is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while busy");
`endif

endmodule

/* rtl/core/pspai_mul.sv */
`timescale 1ns / 1ps
module pspai_mul (
	input  logic                                 clk,
	input  logic signed [pspai_pkg::MUL_AW-1:0]  a,
	input  logic signed [pspai_pkg::MUL_BW-1:0]  b,
	output logic signed [pspai_pkg::MUL_PW-1:0]  p
);
	import pspai_pkg::*;

	// Registered signed product; the result is available in the cycle after issue.
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

/* rtl/core/pspai_div.sv */
`timescale 1ns / 1ps
module pspai_div #(
	parameter int DEN_W = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [pspai_pkg::NUM_W-1:0]      num,
	input  logic [DEN_W-1:0]                 den,
	output pspai_pkg::div_stat_t             stat,
	output logic [pspai_pkg::QUO_W-1:0]      quo
);
	import pspai_pkg::*;

	localparam int DSH_W = DEN_W + QUO_W - 1;

	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QUO_W-1:0] q_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ovf;
	logic             take;

	// A quotient of 2^(QUO_W-1) or more saturates.
	assign ovf  = (num >> QUO_W) >= (NUM_W)'(den);
	assign take = (DSH_W + 1)'(rem_q) >= (DSH_W + 1)'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'(QUO_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= DSH_W'(den) << (QUO_W - 1);
			q_q   <= ovf ? '1 : '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - NUM_W'(dsh_q);
			end
			q_q   <= {q_q[QUO_W-2:0], take};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo = q_q[QUO_W-1] ? {1'b1, {(QUO_W - 1){1'b0}}} : q_q;

endmodule

/* tb/sv/pspai_checker.sv */
`timescale 1ns / 1ps
module pspai_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [pspai_pkg::CFG_IW-1:0] cfg_index,
	input  logic [pspai_pkg::CFG_DW-1:0] cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               cmd,
	input  logic signed [17:0] start_x,
	input  logic signed [17:0] start_y,
	input  logic signed [17:0] start_vx,
	input  logic signed [17:0] start_vy,
	input  logic signed [17:0] swarm_best_x,
	input  logic signed [17:0] swarm_best_y,
	input  logic signed [17:0] source_x,
	input  logic signed [17:0] source_y,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [28:0] score,
	input  logic signed [17:0] pos_x,
	input  logic signed [17:0] pos_y,
	input  logic               on_target,
	output int                 fail_count,
	output int                 pending
);
	import pspai_pkg::*;

	localparam longint POS_LIM = 150 << 8;

	typedef struct {
		logic signed [28:0] score;
		logic signed [17:0] px;
		logic signed [17:0] py;
		logic               hit;
	} particle_report_t;

	particle_report_t expected_reports[$];

	longint exp2_tab [0:16] = '{32768, 34219, 35734, 37316, 38968, 40694, 42495, 44377,
		46341, 48393, 50535, 52773, 55109, 57549, 60097, 62758, 65536};

	longint w0_r, vlim_r, wmin_r, wmax_r, r1_r, r2_r, mhalf_r;
	longint px_s, py_s, vx_s, vy_s, bx_s, by_s, wx_s, wy_s, fit_s, prev_fit;
	logic prev_fit_ok;
	logic [1:0] trend_cur, trend_prev;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint dist_score(longint x, longint y, longint sx, longint sy);
		longint dx, dy, s;
		dx = x - sx;
		dy = y - sy;
		s = (dx * dx + dy * dy) >>> 8;
		if (s > (64'sd1 <<< 28))
			s = 64'sd1 <<< 28;
		return -s;
	endfunction

	function automatic longint exp_weight(longint x);
		longint y, n, m, f, i, sub;
		x = clamp(x, -262144, 65536);
		y = (x * 23637) >>> 14;
		n = y >>> 12;
		f = y & 4095;
		i = f >> 8;
		sub = f & 255;
		m = exp2_tab[i] + (((exp2_tab[i+1] - exp2_tab[i]) * sub) >>> 8);
		if (n >= 4)
			return 65535;
		if (n >= 3)
			return m << (n - 3);
		if (3 - n >= 32)
			return 0;
		return m >> (3 - n);
	endfunction

	function automatic longint adapt_weight(longint w, longint p, longint g);
		longint d, num, den, q, x, step, mh;
		logic up, down;
		up = (trend_cur == TREND_RISE) && (trend_prev == TREND_RISE);
		down = (trend_cur == TREND_FALL) && (trend_prev == TREND_FALL);
		if (!up && !down)
			return w;
		d = p - g;
		mh = (mhalf_r == 0) ? 1 : mhalf_r;
		num = up ? d * d * d : d * d;
		den = (4 * mh * mh) << 12;
		q = (num < 0 ? -num : num) / den;
		x = (num < 0) ? q : -q;
		step = (w0_r * exp_weight(x)) >> 12;
		if (up) begin
			w = w + step;
			return w > wmax_r ? wmax_r : w;
		end
		w = w - step;
		return w < wmin_r ? wmin_r : w;
	endfunction

	function automatic longint next_speed(longint w, longint v, longint p, longint own,
		longint g);
		longint c, sum;
		c = w + 4096;
		sum = w * v * 65536 + c * r1_r * (own - p) + c * r2_r * (g - p);
		return clamp(sum >>> 28, -vlim_r, vlim_r);
	endfunction

	task automatic advance_particle();
		longint gx, gy, sx, sy;
		logic better;
		particle_report_t r;
		sx = source_x;
		sy = source_y;
		if (cmd == CMD_START) begin
			px_s = start_x;
			py_s = start_y;
			vx_s = start_vx;
			vy_s = start_vy;
			bx_s = px_s;
			by_s = py_s;
			wx_s = w0_r;
			wy_s = w0_r;
			fit_s = dist_score(px_s, py_s, sx, sy);
			prev_fit = 0;
			prev_fit_ok = 1'b0;
			trend_cur = TREND_NONE;
			trend_prev = TREND_NONE;
		end else if (fit_s != 0) begin
			gx = swarm_best_x;
			gy = swarm_best_y;
			vx_s = next_speed(wx_s, vx_s, px_s, bx_s, gx);
			vy_s = next_speed(wy_s, vy_s, py_s, by_s, gy);
			px_s = clamp(px_s + vx_s, -POS_LIM, POS_LIM);
			py_s = clamp(py_s + vy_s, -POS_LIM, POS_LIM);
			fit_s = dist_score(px_s, py_s, sx, sy);
			better = !prev_fit_ok || fit_s > prev_fit;
			if (better) begin
				bx_s = px_s;
				by_s = py_s;
			end
			trend_prev = trend_cur;
			trend_cur = better ? TREND_RISE : TREND_FALL;
			prev_fit = fit_s;
			prev_fit_ok = 1'b1;
			wx_s = adapt_weight(wx_s, px_s, gx);
			wy_s = adapt_weight(wy_s, py_s, gy);
		end
		r.score = 29'(fit_s);
		r.px = 18'(px_s);
		r.py = 18'(py_s);
		r.hit = (fit_s == 0);
		expected_reports.push_back(r);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		particle_report_t e;
		if (!arst_n) begin
			w0_r = 2048; vlim_r = 2560; wmin_r = 1024; wmax_r = 4096;
			r1_r = 32768; r2_r = 32768; mhalf_r = 100;
			px_s = 0; py_s = 0; vx_s = 0; vy_s = 0; bx_s = 0; by_s = 0;
			wx_s = 2048; wy_s = 2048; fit_s = 0; prev_fit = 0;
			prev_fit_ok = 1'b0;
			trend_cur = TREND_NONE;
			trend_prev = TREND_NONE;
			expected_reports.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_W0:         w0_r = cfg_data & 17'hFFFF;
					CFG_VEL_LIMIT:  vlim_r = cfg_data;
					CFG_WEIGHT_MIN: wmin_r = cfg_data & 17'hFFFF;
					CFG_WEIGHT_MAX: wmax_r = cfg_data & 17'hFFFF;
					CFG_R1:         r1_r = cfg_data & 17'hFFFF;
					CFG_R2:         r2_r = cfg_data & 17'hFFFF;
					CFG_MAP_HALF:   mhalf_r = cfg_data & 17'h1FF;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$display("tb: result with no transaction waiting");
					fail_count++;
				end else begin
					e = expected_reports.pop_front();
					if (score !== e.score) report_mismatch("score", score, e.score);
					if (pos_x !== e.px) report_mismatch("pos_x", pos_x, e.px);
					if (pos_y !== e.py) report_mismatch("pos_y", pos_y, e.py);
					if (on_target !== e.hit) report_mismatch("on_target", on_target, e.hit);
				end
			end
			if (in_valid && in_ready)
				advance_particle();
		end
		pending = expected_reports.size();
	end
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import pspai_pkg::*;

	// Generous cycle limit; the slowest correct run is far below it.
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 140;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_START;
	logic signed [17:0] start_x = '0, start_y = '0, start_vx = '0, start_vy = '0;
	logic signed [17:0] swarm_best_x = '0, swarm_best_y = '0;
	logic signed [17:0] source_x = '0, source_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [28:0] score;
	logic signed [17:0] pos_x, pos_y;
	logic on_target;
	int fail_count, pending;
	int cycles = 0;

	// Burst state of the sender: how many more transactions go back to back.
	int burst_left = 0;
	// Stall pattern of the receiver: 0 always ready, 1 random, 2 long stalls.
	int stall_mode = 0;
	int stall_len = 0;

	// Current episode: the source and swarm best that steps orbit around.
	logic signed [17:0] ep_src_x, ep_src_y, ep_best_x, ep_best_y;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pso_particle_adaptive_inertia dut (.*);

	pspai_checker chk (.*);

	// The run is cut short if anything hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// The receiver switches between patterns now and then, so stalls land on every
	// phase of the work and there are also stretches with no stall at all.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		if (stall_len > 0) begin
			stall_len <= stall_len - 1;
			out_ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						stall_len <= $urandom_range(5, 60);
						out_ready <= 1'b0;
					end else
						out_ready <= 1'b1;
				end
			endcase
		end
	end

	function automatic logic signed [17:0] any18();
		return 18'($urandom);
	endfunction

	function automatic logic signed [17:0] near(logic signed [17:0] c, int span);
		longint v;
		v = c + $signed($urandom_range(0, 2 * span)) - span;
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return 18'(v);
	endfunction

	// Presents one transaction and returns once it has been accepted. Valid stays
	// high into the next transaction unless a gap is due.
	task automatic send_item(logic c, logic signed [17:0] sx, logic signed [17:0] sy,
		logic signed [17:0] svx, logic signed [17:0] svy, logic signed [17:0] gx,
		logic signed [17:0] gy, logic signed [17:0] qx, logic signed [17:0] qy);
		in_valid <= 1'b1;
		cmd <= c;
		start_x <= sx;
		start_y <= sy;
		start_vx <= svx;
		start_vy <= svy;
		swarm_best_x <= gx;
		swarm_best_y <= gy;
		source_x <= qx;
		source_y <= qy;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	endtask

	// Waits until every expected result is in, then lets the block's longest step
	// finish in case it is still busy.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_regs(int w0, int vl, int wmin, int wmax, int r1, int r2, int mh);
		int vals [7];
		vals = '{w0, vl, wmin, wmax, r1, r2, mh};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[CFG_IW-1:0];
			cfg_data <= vals[i][CFG_DW-1:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic new_episode();
		ep_src_x = near(0, 38000);
		ep_src_y = near(0, 38000);
		ep_best_x = near(ep_src_x, 3000);
		ep_best_y = near(ep_src_y, 3000);
		send_item(CMD_START, near(0, 40000), near(0, 40000), near(0, 3000), near(0, 3000),
			any18(), any18(), ep_src_x, ep_src_y);
	endtask

	// Mostly well formed episodes: a start followed by many steps around one source,
	// with a little noise and the odd start right on the source.
	task automatic random_phase(int count);
		int k;
		k = 0;
		new_episode();
		while (k < count) begin
			case ($urandom_range(0, 19))
				0: new_episode();
				1: send_item(1'($urandom_range(0, 1)), any18(), any18(), any18(), any18(),
					any18(), any18(), any18(), any18());
				2: send_item(CMD_START, ep_src_x, ep_src_y, any18(), any18(), any18(),
					any18(), ep_src_x, ep_src_y);
				3: begin
					ep_best_x = near(ep_src_x, 3000);
					ep_best_y = near(ep_src_y, 3000);
					send_item(CMD_STEP, any18(), any18(), any18(), any18(), ep_best_x,
						ep_best_y, ep_src_x, ep_src_y);
				end
				default: send_item(CMD_STEP, any18(), any18(), any18(), any18(), ep_best_x,
					ep_best_y, ep_src_x, ep_src_y);
			endcase
			k++;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration. Steps before any start only
		// report the reset state, since its zero score counts as frozen.
		send_item(CMD_STEP, 18'sh1FFFF, -18'sh20000, 0, 0, 18'sh1FFFF, -18'sh20000,
			18'sh1FFFF, -18'sh20000);
		send_item(CMD_STEP, 0, 0, 0, 0, -18'sh20000, 18'sh1FFFF, 100, -100);
		// Extreme start position, far outside the clamp, and extreme speed.
		send_item(CMD_START, 18'sh1FFFF, -18'sh20000, -18'sh20000, 18'sh1FFFF, 0, 0,
			-18'sh20000, 18'sh1FFFF);
		repeat (4) send_item(CMD_STEP, 0, 0, 0, 0, 18'sh1FFFF, -18'sh20000,
			-18'sh20000, 18'sh1FFFF);
		// Start right on the source: frozen, and steps leave it alone.
		send_item(CMD_START, 1234, -567, 900, -900, 0, 0, 1234, -567);
		repeat (2) send_item(CMD_STEP, 0, 0, 0, 0, 5000, 5000, 1234, -567);
		// A near approach so the trends both rise and both fall.
		send_item(CMD_START, 2000, -1500, 300, -300, 0, 0, 0, 0);
		repeat (8) send_item(CMD_STEP, 0, 0, 0, 0, 10, -10, 0, 0);
		send_item(CMD_START, -38400, 38400, 0, 0, 0, 0, 38400, -38400);
		repeat (4) send_item(CMD_STEP, 0, 0, 0, 0, -38400, 38400, 38400, -38400);

		random_phase(PHASE_ITEMS);

		// The sender holds off here until every result is back.
		drain();
		write_regs(0, 0, 0, 0, 0, 0, 1);
		random_phase(PHASE_ITEMS / 2);

		drain();
		// Top of every range, with the weight bounds crossed.
		write_regs(65535, 131071, 65535, 0, 65535, 65535, 511);
		random_phase(PHASE_ITEMS / 2);

		drain();
		// A zero map size is treated as one.
		write_regs(4096, 1024, 512, 12000, 60000, 20000, 0);
		random_phase(PHASE_ITEMS);

		drain();
		write_regs($urandom_range(0, 65535), $urandom_range(0, 131071),
			$urandom_range(0, 8000), $urandom_range(4000, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(1, 511));
		random_phase(PHASE_ITEMS);

		drain();
		write_regs(2048, 2560, 1024, 4096, 32768, 32768, 100);
		random_phase(PHASE_ITEMS);

		drain();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
